// File: rtl/pd_attitude_torque_allocator_unit_assert.svh
// Assertion macros for the attitude torque allocator
`ifndef PD_ATTITUDE_TORQUE_ALLOCATOR_UNIT_ASSERT_SVH
`define PD_ATTITUDE_TORQUE_ALLOCATOR_UNIT_ASSERT_SVH
`define PDA_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define PDA_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// File: rtl/pda_pkg.sv
// Shared constants and a saturation function for the attitude torque allocator
package pda_pkg;
  localparam int AXES = 3;
  localparam int GAIN_W = 18;
  localparam logic [2:0] REG_KP_X = 3'd0;
  localparam logic [2:0] REG_KP_Y = 3'd1;
  localparam logic [2:0] REG_KP_Z = 3'd2;
  localparam logic [2:0] REG_KD_X = 3'd3;
  localparam logic [2:0] REG_KD_Y = 3'd4;
  localparam logic [2:0] REG_KD_Z = 3'd5;
  localparam logic [GAIN_W-1:0] KP_RST_XY = 18'd6554;
  localparam logic [GAIN_W-1:0] KP_RST_Z = 18'd3277;
  localparam logic [GAIN_W-1:0] KD_RST_XY = 18'd32768;
  localparam logic [GAIN_W-1:0] KD_RST_Z = 18'd16384;
  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = S32_MAX;
    else if (v < -64'sd2147483648) r = S32_MIN;
    else r = v[31:0];
    return r;
  endfunction
endpackage

// File: rtl/pda_serial_mult.sv
// Bit-serial shift-add multiplier, unsigned 34 x 18
module pda_serial_mult (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [33:0] a,
  input  logic [17:0] b,
  output logic        done,
  output logic [51:0] prod
);
  logic [17:0] mb;
  logic [51:0] ma;
  logic [4:0]  cnt;
  logic        busy;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= 5'd18;
      mb <= b;
      ma <= {18'd0, a};
      prod <= '0;
    end else if (busy) begin
      if (mb[0]) prod <= prod + ma;
      ma <= ma << 1;
      mb <= mb >> 1;
      cnt <= cnt - 5'd1;
      if (cnt == 5'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule

// File: rtl/pda_serial_sqrt.sv
// Bit-serial integer square root, two radicand bits per cycle
module pda_serial_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [65:0] n,
  output logic        done,
  output logic [32:0] root
);
  logic [65:0] rem_sh;
  logic [35:0] part;
  logic [5:0]  cnt;
  logic        busy;
  logic [35:0] trial;
  logic [35:0] cur;

  assign cur = {part[33:0], rem_sh[65:64]};
  assign trial = {1'b0, root[32:0], 2'b01};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= 6'd33;
      rem_sh <= n;
      part <= '0;
      root <= '0;
    end else if (busy) begin
      rem_sh <= rem_sh << 2;
      if (cur >= trial) begin
        part <= cur - trial;
        root <= {root[31:0], 1'b1};
      end else begin
        part <= cur;
        root <= {root[31:0], 1'b0};
      end
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule

// File: rtl/pda_serial_div.sv
// Bit-serial restoring divider, 50-bit dividend by 37-bit divisor
module pda_serial_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [49:0] num,
  input  logic [36:0] den,
  output logic        done,
  output logic [49:0] quo
);
  logic [37:0] rem;
  logic [36:0] d;
  logic [5:0]  cnt;
  logic        busy;
  logic [37:0] sh;

  assign sh = {rem[36:0], quo[49]};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= 6'd50;
      rem <= '0;
      quo <= num;
      d <= den;
    end else if (busy) begin
      if (sh >= {1'b0, d}) begin
        rem <= sh - {1'b0, d};
        quo <= {quo[48:0], 1'b1};
      end else begin
        rem <= sh;
        quo <= {quo[48:0], 1'b0};
      end
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule

// File: rtl/pd_attitude_torque_allocator_unit.sv
// Top level of the three-axis PD attitude torque allocator
// channel | direction | handshake      | payload
// in      | input     | in_valid/stall | meas, target, field per axis
// out     | output    | out_valid/stall| torque, wheel_mom, dipole, thrust
// cfg     | input     | cfg_we         | cfg_index, cfg_data
// One request at a time: in_stall holds off the next request until the result
// has been taken from the output.
// Field squares and per-axis gain products use a serial shift-add multiplier;
// the magnitude takes the serial root, and each axis a serial divider pass.
// rst is synchronous and clears gains to defaults and momentum to zero.
// in_stall is high in every state but idle, also while the result is presented.
module pd_attitude_torque_allocator_unit (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [31:0] meas_x, meas_y, meas_z,
  input  logic signed [31:0] target_x, target_y, target_z,
  input  logic signed [31:0] field_x, field_y, field_z,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [31:0] torque_x, torque_y, torque_z,
  output logic signed [31:0] wheel_mom_x, wheel_mom_y, wheel_mom_z,
  output logic signed [31:0] dipole_x, dipole_y, dipole_z,
  output logic signed [31:0] thrust_x, thrust_y, thrust_z,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [17:0] cfg_data
);
  localparam logic [3:0] S_IDLE = 4'd0, S_SQ = 4'd1, S_SQW = 4'd2, S_RT = 4'd3,
    S_RTW = 4'd4, S_KP = 4'd5, S_KPW = 4'd6, S_KD = 4'd7, S_KDW = 4'd8,
    S_DV = 4'd9, S_DVW = 4'd10, S_OUT = 4'd11;

  logic [3:0] state;
  logic [1:0] ax;
  logic [17:0] kp [3];
  logic [17:0] kd [3];
  logic signed [31:0] mom [3];
  logic signed [31:0] ms [3], tg [3], fd [3];
  logic signed [31:0] tq [3], mo [3], dp [3], th [3];
  logic [65:0] sumsq;
  logic [32:0] mag;
  logic signed [64:0] acc;

  logic m_start, m_done, r_start, r_done, d_start, d_done;
  logic [33:0] m_a;
  logic [17:0] m_b;
  logic [51:0] m_p;
  logic [32:0] r_root;
  logic [49:0] d_q;
  logic [49:0] d_num;

  logic signed [32:0] err;
  logic [32:0] aerr, ameas, afld;
  logic signed [63:0] tq64;
  logic signed [31:0] tqs, tqv, hv;
  logic [31:0] atq;
  logic signed [50:0] dq;

  assign err = 33'(tg[ax]) - 33'(ms[ax]);
  assign aerr = err[32] ? 33'(-err) : err;
  assign ameas = ms[ax][31] ? 33'(-34'(ms[ax])) : 33'(ms[ax]);
  assign afld = fd[ax][31] ? 33'(-34'(fd[ax])) : 33'(fd[ax]);
  assign tq64 = 64'(acc >>> 16);
  assign tqs = pda_pkg::sat32(tq64);
  assign tqv = tq[ax];
  assign hv = tqv >>> 1;
  assign atq = tqs[31] ? 32'(-33'(tqs)) : 32'(tqs);
  assign d_num = 50'(atq) * 50'd196608;
  assign dq = (d_q > 50'h80000000) ? 51'h80000000 : 51'(d_q);

  always_comb begin
    case (state)
      S_SQ: begin m_a = {1'b0, afld}; m_b = 18'd0; end
      S_KP: begin m_a = {1'b0, aerr}; m_b = kp[ax]; end
      S_KD: begin m_a = {1'b0, ameas}; m_b = kd[ax]; end
      default: begin m_a = '0; m_b = '0; end
    endcase
  end

  // square each field in two passes over the low and high multiplier digits
  logic [1:0] part;
  logic [33:0] sq_a;
  logic [17:0] sq_b;
  logic [33:0] ma_sel;
  logic [17:0] mb_sel;
  always_comb begin
    ma_sel = m_a;
    mb_sel = m_b;
    if (state == S_SQ) begin
      ma_sel = sq_a;
      mb_sel = sq_b;
    end
  end
  assign sq_a = {1'b0, afld};
  assign sq_b = part[0] ? {3'd0, afld[32:18]} : afld[17:0];

  pda_serial_mult u_mult (.clk, .rst, .start(m_start), .a(ma_sel), .b(mb_sel),
    .done(m_done), .prod(m_p));
  pda_serial_sqrt u_sqrt (.clk, .rst, .start(r_start), .n(sumsq), .done(r_done),
    .root(r_root));
  pda_serial_div u_div (.clk, .rst, .start(d_start), .num(d_num),
    .den(37'(mag) * 37'd10), .done(d_done), .quo(d_q));

  assign m_start = (state == S_SQ) || (state == S_KP) || (state == S_KD);
  assign r_start = (state == S_RT);
  assign d_start = (state == S_DV);
  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ax <= '0;
      part <= '0;
      kp[0] <= pda_pkg::KP_RST_XY; kp[1] <= pda_pkg::KP_RST_XY;
      kp[2] <= pda_pkg::KP_RST_Z;
      kd[0] <= pda_pkg::KD_RST_XY; kd[1] <= pda_pkg::KD_RST_XY;
      kd[2] <= pda_pkg::KD_RST_Z;
      for (int i = 0; i < 3; i++) mom[i] <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pda_pkg::REG_KP_X: kp[0] <= cfg_data;
          pda_pkg::REG_KP_Y: kp[1] <= cfg_data;
          pda_pkg::REG_KP_Z: kp[2] <= cfg_data;
          pda_pkg::REG_KD_X: kd[0] <= cfg_data;
          pda_pkg::REG_KD_Y: kd[1] <= cfg_data;
          pda_pkg::REG_KD_Z: kd[2] <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: if (in_valid) begin
          ms[0] <= meas_x; ms[1] <= meas_y; ms[2] <= meas_z;
          tg[0] <= target_x; tg[1] <= target_y; tg[2] <= target_z;
          fd[0] <= field_x; fd[1] <= field_y; fd[2] <= field_z;
          sumsq <= '0; ax <= '0; part <= '0;
          state <= S_SQ;
        end
        S_SQ: state <= S_SQW;
        S_SQW: if (m_done) begin
          sumsq <= sumsq + (part[0] ? (66'(m_p) << 18) : 66'(m_p));
          if (part[0]) begin
            part <= '0;
            if (ax == 2'd2) begin ax <= '0; state <= S_RT; end
            else begin ax <= ax + 2'd1; state <= S_SQ; end
          end else begin
            part <= 2'd1;
            state <= S_SQ;
          end
        end
        S_RT: state <= S_RTW;
        S_RTW: if (r_done) begin mag <= r_root; state <= S_KP; end
        S_KP: state <= S_KPW;
        S_KPW: if (m_done) begin
          acc <= err[32] ? -65'(m_p) : 65'(m_p);
          state <= S_KD;
        end
        S_KD: state <= S_KDW;
        S_KDW: if (m_done) begin
          acc <= acc - (ms[ax][31] ? -65'(m_p) : 65'(m_p));
          state <= S_DV;
        end
        S_DV: begin
          tq[ax] <= tqs;
          state <= S_DVW;
        end
        S_DVW: if (d_done || mag == '0) begin
          mo[ax] <= pda_pkg::sat32(64'(mom[ax]) + 64'(hv));
          mom[ax] <= pda_pkg::sat32(64'(mom[ax]) + 64'(hv));
          th[ax] <= pda_pkg::sat32(64'(tqv) * 64'sd2);
          if (mag == '0)
            dp[ax] <= tqv[31] ? pda_pkg::S32_MIN :
              ((tqv == 0) ? 32'sd0 : pda_pkg::S32_MAX);
          else
            dp[ax] <= pda_pkg::sat32(tqv[31] ? -64'(dq) : 64'(dq));
          if (ax == 2'd2) state <= S_OUT;
          else begin ax <= ax + 2'd1; state <= S_KP; end
        end
        S_OUT: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign torque_x = tq[0]; assign torque_y = tq[1]; assign torque_z = tq[2];
  assign wheel_mom_x = mo[0]; assign wheel_mom_y = mo[1]; assign wheel_mom_z = mo[2];
  assign dipole_x = dp[0]; assign dipole_y = dp[1]; assign dipole_z = dp[2];
  assign thrust_x = th[0]; assign thrust_y = th[1]; assign thrust_z = th[2];
endmodule

// File: rtl/pda_checker.sv
// Port-level checker for the attitude torque allocator
`include "pd_attitude_torque_allocator_unit_assert.svh"
module pda_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic signed [31:0] torque_x,
  input logic signed [31:0] thrust_x
);
  `PDA_ASSERT_NXT(a_hold, out_valid && out_stall, out_valid && $stable(torque_x))
  `PDA_ASSERT_IMP(a_busy, out_valid, in_stall)
  `PDA_ASSERT_NXT(a_start, in_valid && !in_stall, in_stall && !out_valid)
  `PDA_ASSERT_IMP(a_thr, out_valid && torque_x > 0 && torque_x < 32'sh3fffffff,
    thrust_x == torque_x * 2)
endmodule

bind pd_attitude_torque_allocator_unit pda_checker u_chk (.clk, .rst, .in_valid,
  .in_stall, .out_valid, .out_stall, .torque_x, .thrust_x);
